>>> src/jbrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jbrt_pkg;

    // Field and register widths
    localparam int BASE_W  = 16;
    localparam int CAP_W   = 19;
    localparam int SEED_W  = 32;
    localparam int DELAY_W = 19;
    localparam int FAIL_W  = 5;
    localparam int SPAN_W  = 16;
    localparam int MOD_W   = SPAN_W + 1;

    // Register reset values
    localparam logic [BASE_W-1:0] BASE_RESET = 16'd1000;
    localparam logic [CAP_W-1:0]  CAP_RESET  = 19'd30000;
    localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;

    // Failure count saturation
    localparam int FAIL_LIMIT_DEF = 30;

    // Jitter generator constants
    localparam logic [SEED_W-1:0] LCG_MUL = 32'd1103515245;
    localparam logic [SEED_W-1:0] LCG_ADD = 32'd12345;

    // Divide by ten as multiply by reciprocal, exact for 19-bit operands
    localparam int               DIV10_SHIFT = 23;
    localparam int               RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] DIV10_RECIP = 20'd838861;

    localparam logic [DELAY_W-1:0] DELAY_MAX = 19'h7FFFF;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_BASE_INTERVAL = 2'd0,
        CFG_BACKOFF_CAP   = 2'd1,
        CFG_RNG_SEED      = 2'd2
    } jbrt_cfg_idx_t;

    // Input kinds
    localparam logic OP_START   = 1'b0;
    localparam logic OP_OUTCOME = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BACKOFF,
        ST_SPAN,
        ST_LCG,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SUM,
        ST_DONE
    } jbrt_state_t;

endpackage

`default_nettype wire

>>> src/jbrt_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Serial restoring remainder unit: one quotient bit per cycle
module jbrt_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [jbrt_pkg::SEED_W-1:0] dividend,
    input  wire logic [jbrt_pkg::MOD_W-1:0]  divisor,
    output logic                           done,
    output logic [jbrt_pkg::MOD_W-1:0]     remainder
);

    localparam int DVD_W = jbrt_pkg::SEED_W;
    localparam int DSR_W = jbrt_pkg::MOD_W;
    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W:0]   rem_shift;
    logic [DSR_W:0]   rem_diff;

    // Shift in the next dividend bit and trial-subtract
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            if (rem_shift >= {1'b0, dsr_reg}) begin
                rem_reg <= rem_diff[DSR_W-1:0];
            end else begin
                rem_reg <= rem_shift[DSR_W-1:0];
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> src/jittered_backoff_retry_timer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// A word with jitter loads its span, advances the generator, runs the serial remainder over
// the 32-bit generator state, then sums and loads the output register for m_tvalid.
// An outcome word first doubles in the backoff state (at most 18 doublings, 19-bit cap).
// A delay under 10 ms skips the remainder and the sum; its result is the backed-off delay.
// Throughput: one word at a time; the next is accepted the cycle after the result loads,
// and a result held by m_tready stalls the sequencer. Reset: registers to defaults, gen 0.

module jittered_backoff_retry_timer_unit #(
    parameter int FAIL_LIMIT = jbrt_pkg::FAIL_LIMIT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] attempt_ok, [7:1] zero
    input  wire logic        s_tuser,   // [0] op
    // Result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [18:0] retry_wait, [19] reachable,
                                        // [24:20] fail_count, [31:25] zero
    // Configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int BASE_W  = jbrt_pkg::BASE_W;
    localparam int CAP_W   = jbrt_pkg::CAP_W;
    localparam int SEED_W  = jbrt_pkg::SEED_W;
    localparam int DELAY_W = jbrt_pkg::DELAY_W;
    localparam int FAIL_W  = jbrt_pkg::FAIL_W;
    localparam int SPAN_W  = jbrt_pkg::SPAN_W;
    localparam int MOD_W   = jbrt_pkg::MOD_W;
    localparam int PROD_W  = DELAY_W + jbrt_pkg::RECIP_W;
    localparam int SUM_W   = DELAY_W + 1;
    localparam logic [FAIL_W-1:0] FAIL_LIM = FAIL_W'(FAIL_LIMIT);

    // Configuration registers
    logic [BASE_W-1:0] base_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [SEED_W-1:0] seed_reg;

    // Block state
    logic [SEED_W-1:0] rng_reg;
    logic [FAIL_W-1:0] fails_reg;
    logic              reach_reg;

    // Sequencer and datapath
    jbrt_pkg::jbrt_state_t state_reg, state_next;
    logic [DELAY_W-1:0] d_reg;
    logic [DELAY_W-1:0] c_reg;
    logic [FAIL_W-1:0]  iter_reg;
    logic [SPAN_W-1:0]  span_reg;
    logic [DELAY_W-1:0] result_reg;

    // Output register
    logic               m_valid_reg;
    logic [DELAY_W-1:0] m_delay_reg;
    logic               m_reach_reg;
    logic [FAIL_W-1:0]  m_fail_reg;

    logic               accept;
    logic               div_start;
    logic               div_done;
    logic               out_load;
    logic [MOD_W-1:0]   div_rem;
    logic [MOD_W-1:0]   modulus;
    logic [BASE_W-1:0]  eff_base;
    logic [DELAY_W-1:0] eff_cap;
    logic               back_stop;
    logic               back_clamp;
    logic [PROD_W-1:0]  span_prod;
    logic [SEED_W-1:0]  rng_next;
    logic [SUM_W-1:0]   sum;
    logic [DELAY_W-1:0] sum_sat;

    // Effective base and cap
    assign eff_base = (base_reg == '0) ? BASE_W'(1) : base_reg;
    assign eff_cap  = (cap_reg > DELAY_W'(eff_base)) ? cap_reg : DELAY_W'(eff_base);

    // Shared doubling step: stop at count or cap, clamp past half cap
    assign back_stop  = (iter_reg >= fails_reg) || (d_reg >= c_reg);
    assign back_clamp = d_reg > (c_reg >> 1);

    // Span is delay / 10 by reciprocal
    assign span_prod = PROD_W'(d_reg) * PROD_W'(jbrt_pkg::DIV10_RECIP);

    // Generator advance, modulo 2^32
    assign rng_next = rng_reg * jbrt_pkg::LCG_MUL + jbrt_pkg::LCG_ADD;

    assign modulus = {span_reg, 1'b1};

    // Offset delay, then saturate and floor
    assign sum = SUM_W'(d_reg) + SUM_W'(div_rem) - SUM_W'(span_reg);
    always_comb begin
        if (sum > SUM_W'(jbrt_pkg::DELAY_MAX)) begin
            sum_sat = jbrt_pkg::DELAY_MAX;
        end else if (sum == '0) begin
            sum_sat = DELAY_W'(1);
        end else begin
            sum_sat = sum[DELAY_W-1:0];
        end
    end

    jbrt_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (rng_reg),
        .divisor   (modulus),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            jbrt_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == jbrt_pkg::OP_START) ?
                                 jbrt_pkg::ST_SPAN : jbrt_pkg::ST_BACKOFF;
                end
            end
            jbrt_pkg::ST_BACKOFF: begin
                if (back_stop || back_clamp) begin
                    state_next = jbrt_pkg::ST_SPAN;
                end
            end
            jbrt_pkg::ST_SPAN:     state_next = jbrt_pkg::ST_LCG;
            jbrt_pkg::ST_LCG: begin
                state_next = (span_reg == '0) ? jbrt_pkg::ST_DONE : jbrt_pkg::ST_DIV_GO;
            end
            jbrt_pkg::ST_DIV_GO:   state_next = jbrt_pkg::ST_DIV_WAIT;
            jbrt_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = jbrt_pkg::ST_SUM;
                end
            end
            jbrt_pkg::ST_SUM:      state_next = jbrt_pkg::ST_DONE;
            jbrt_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = jbrt_pkg::ST_IDLE;
                end
            end
            default:               state_next = jbrt_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            jbrt_pkg::ST_IDLE:     s_tready  = 1'b1;
            jbrt_pkg::ST_DIV_GO:   div_start = 1'b1;
            jbrt_pkg::ST_DONE:     out_load  = !m_valid_reg || m_tready;
            default: begin
            end
        endcase
    end

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Control state, configuration and block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= jbrt_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            base_reg    <= jbrt_pkg::BASE_RESET;
            cap_reg     <= jbrt_pkg::CAP_RESET;
            seed_reg    <= jbrt_pkg::SEED_RESET;
            rng_reg     <= '0;
            fails_reg   <= '0;
            reach_reg   <= 1'b1;
        end else begin
            state_reg <= state_next;

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    jbrt_pkg::CFG_BASE_INTERVAL: base_reg <= cfg_data[BASE_W-1:0];
                    jbrt_pkg::CFG_BACKOFF_CAP:   cap_reg  <= cfg_data[CAP_W-1:0];
                    jbrt_pkg::CFG_RNG_SEED:      seed_reg <= cfg_data[SEED_W-1:0];
                    default: begin
                    end
                endcase
            end

            // Update outcome state on accept
            if (accept) begin
                if (s_tuser == jbrt_pkg::OP_START) begin
                    rng_reg   <= seed_reg;
                    fails_reg <= '0;
                    reach_reg <= 1'b1;
                end else if (s_tdata[0]) begin
                    fails_reg <= '0;
                    reach_reg <= 1'b1;
                end else begin
                    reach_reg <= 1'b0;
                    if (fails_reg < FAIL_LIM) begin
                        fails_reg <= fails_reg + FAIL_W'(1);
                    end
                end
            end

            // Advance the generator only when jitter applies
            if (state_reg == jbrt_pkg::ST_LCG && span_reg != '0) begin
                rng_reg <= rng_next;
            end
        end
    end

    // Delay datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            jbrt_pkg::ST_IDLE: begin
                d_reg    <= DELAY_W'(eff_base);
                c_reg    <= eff_cap;
                iter_reg <= '0;
            end
            jbrt_pkg::ST_BACKOFF: begin
                if (!back_stop) begin
                    if (back_clamp) begin
                        d_reg <= c_reg;
                    end else begin
                        d_reg    <= {d_reg[DELAY_W-2:0], 1'b0};
                        iter_reg <= iter_reg + FAIL_W'(1);
                    end
                end
            end
            jbrt_pkg::ST_SPAN: begin
                span_reg <= span_prod[PROD_W-1:jbrt_pkg::DIV10_SHIFT];
            end
            jbrt_pkg::ST_LCG: begin
                result_reg <= d_reg;
            end
            jbrt_pkg::ST_SUM: begin
                result_reg <= sum_sat;
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_delay_reg <= result_reg;
            m_reach_reg <= reach_reg;
            m_fail_reg  <= fails_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_fail_reg, m_reach_reg, m_delay_reg};

    // Remainder unit reports only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == jbrt_pkg::ST_DIV_WAIT)
        else $error("remainder done outside wait state");

    // Failure count never passes its limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        fails_reg <= FAIL_LIM)
        else $error("failure count above limit");

    // Backed-off delay never exceeds the effective cap
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == jbrt_pkg::ST_SPAN |-> d_reg <= c_reg)
        else $error("backed-off delay above cap");

    // A delivered delay is never zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[DELAY_W-1:0] != '0)
        else $error("zero delay on output");

    // An accepted word leaves the idle state
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != jbrt_pkg::ST_IDLE)
        else $error("accepted word did not start work");

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int BASE_W  = jbrt_pkg::BASE_W;
    localparam int CAP_W   = jbrt_pkg::CAP_W;
    localparam int SEED_W  = jbrt_pkg::SEED_W;
    localparam int DELAY_W = jbrt_pkg::DELAY_W;
    localparam int FAIL_W  = jbrt_pkg::FAIL_W;

    // Index that no register answers to
    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;
    localparam logic       ATTEMPT_FAIL   = 1'b0;
    localparam logic       ATTEMPT_OK     = 1'b1;
    localparam int         WORDS_PER_BLK  = 100;
    localparam int         SETTLE_CYCLES  = 80;

    // Same bit order as the result word: fail_count on top, wait in the low bits
    typedef struct packed {
        logic [FAIL_W-1:0]  fails;
        logic               reach;
        logic [DELAY_W-1:0] delay;
    } retry_result_t;

    typedef struct packed {
        logic          is_cfg;
        logic [1:0]    idx;
        logic [31:0]   data;
        logic          op;
        logic          ok;
        logic          typed;
        retry_result_t res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // Scheduler model: registers and state
    logic [BASE_W-1:0]  cfg_base;
    logic [CAP_W-1:0]   cfg_cap;
    logic [SEED_W-1:0]  cfg_seed;
    logic [31:0]        gen_state;
    logic [FAIL_W-1:0]  fail_cnt;
    logic               reach_flag;

    retry_result_t pending_delays[$];
    stim_row_t     stim_table[$];

    int sender_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int words_sent;
    int results_seen;
    int reg_writes;
    int at_fail_limit;
    int at_delay_ceiling;

    jittered_backoff_retry_timer_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [0] attempt_ok, [7:1] zero
        .s_tuser   (s_tuser),   // [0] op
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [18:0] retry_wait, [19] reachable, [24:20] fail_count
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Add LCG jitter of +/- one tenth, clamp to the output range
    function automatic logic [DELAY_W-1:0] jittered(input logic [31:0] nominal);
        logic [31:0] span;
        logic [31:0] rem;
        logic [31:0] sum;
        span = nominal / 10;
        if (span == 0)
            return nominal[DELAY_W-1:0];
        gen_state = gen_state * jbrt_pkg::LCG_MUL + jbrt_pkg::LCG_ADD;
        rem = gen_state % (2 * span + 1);
        sum = nominal + rem - span;
        if (sum < 1)
            sum = 1;
        if (sum > {13'd0, jbrt_pkg::DELAY_MAX})
            sum = {13'd0, jbrt_pkg::DELAY_MAX};
        return sum[DELAY_W-1:0];
    endfunction

    // Advance the model by one input word and return its result
    function automatic retry_result_t predict_retry(input logic op, input logic ok);
        retry_result_t res;
        logic [31:0]   b;
        logic [31:0]   c;
        logic [31:0]   d;
        int            i;
        b = (cfg_base == 0) ? 32'd1 : {16'd0, cfg_base};
        if (op == jbrt_pkg::OP_START) begin
            gen_state  = cfg_seed;
            fail_cnt   = '0;
            reach_flag = 1'b1;
            res.delay  = jittered(b);
        end else begin
            if (ok == ATTEMPT_OK) begin
                reach_flag = 1'b1;
                fail_cnt   = '0;
            end else begin
                reach_flag = 1'b0;
                if (fail_cnt < jbrt_pkg::FAIL_LIMIT_DEF)
                    fail_cnt = fail_cnt + FAIL_W'(1);
            end
            // double once per failure, hold at the cap
            c = ({13'd0, cfg_cap} > b) ? {13'd0, cfg_cap} : b;
            d = b;
            for (i = 0; i < fail_cnt; i++) begin
                if (d >= c)
                    break;
                if (d > c / 2) begin
                    d = c;
                    break;
                end
                d = d * 2;
            end
            if (d > c)
                d = c;
            res.delay = jittered(d);
        end
        res.reach = reach_flag;
        res.fails = fail_cnt;
        return res;
    endfunction

    function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [31:0] data);
        stim_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        return row;
    endfunction

    function automatic stim_row_t item_row(input logic op, input logic ok);
        stim_row_t row;
        row    = '0;
        row.op = op;
        row.ok = ok;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic op, input logic ok,
                                            input logic [DELAY_W-1:0] delay,
                                            input logic reach, input logic [FAIL_W-1:0] fails);
        stim_row_t row;
        row           = item_row(op, ok);
        row.typed     = 1'b1;
        row.res.delay = delay;
        row.res.reach = reach;
        row.res.fails = fails;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("tb: mismatch in %s at %0t ns: got %0d, want %0d", what, $time, got, want);
    endtask

    // Send one word; entered and left just after a falling edge
    task automatic send_word(input logic op, input logic ok, input logic use_typed,
                             input retry_result_t typed_res);
        retry_result_t model_res;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, ok};
        do
            @(posedge aclk);
        while (!s_tready);
        model_res = predict_retry(op, ok);
        pending_delays.push_back(use_typed ? typed_res : model_res);
        words_sent++;
        @(negedge aclk);
    endtask

    // Drop the input and wait until every result is back
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (pending_delays.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            jbrt_pkg::CFG_BASE_INTERVAL: cfg_base = data[BASE_W-1:0];
            jbrt_pkg::CFG_BACKOFF_CAP:   cfg_cap  = data[CAP_W-1:0];
            jbrt_pkg::CFG_RNG_SEED:      cfg_seed = data;
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Pick a register setting for one random block
    task automatic configure_block(input int blk);
        logic [31:0] base_w;
        logic [31:0] cap_w;
        base_w = $urandom_range(100, 60000);
        cap_w  = $urandom_range(1000, 300000);
        if (blk == 0) begin
            base_w = 100;
            cap_w  = 1000;
        end else if (blk == 4) begin
            base_w = 60000;
            cap_w  = 300000;
        end else if (blk == 7) begin
            base_w = $urandom_range(0, 20);
            cap_w  = $urandom_range(0, 200);
        end else if ($urandom_range(0, 1) == 1) begin
            base_w = $urandom;
            cap_w  = $urandom;
        end
        quiesce();
        write_reg(jbrt_pkg::CFG_BASE_INTERVAL, base_w);
        write_reg(jbrt_pkg::CFG_BACKOFF_CAP, cap_w);
        write_reg(jbrt_pkg::CFG_RNG_SEED,
                  (blk == 0) ? 32'd0 : (blk == 4) ? 32'hFFFF_FFFF : $urandom);
    endtask

    // One retry session: start, a run of failures, a few mixed outcomes;
    // now and then stray words instead
    task automatic run_retry_burst(inout int count);
        int n;
        int i;
        if ($urandom_range(0, 9) < 8) begin
            send_word(jbrt_pkg::OP_START, 1'($urandom_range(0, 1)), 1'b0, '0);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(25, 34) : $urandom_range(0, 12);
            for (i = 0; i < n; i++)
                send_word(jbrt_pkg::OP_OUTCOME, ATTEMPT_FAIL, 1'b0, '0);
            count += n + 1;
            n = $urandom_range(0, 2);
        end else begin
            n = $urandom_range(1, 4);
        end
        for (i = 0; i < n; i++)
            send_word($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)), 1'b0, '0);
        count += n;
    endtask

    // Hold or release the result channel at random
    always @(negedge aclk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Compare each result word with the oldest expectation
    always @(posedge aclk) begin : check_results
        retry_result_t got;
        retry_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[DELAY_W+FAIL_W:0];
            results_seen++;
            if (pending_delays.size() == 0) begin
                report_mismatch("unexpected result word", m_tdata, 0);
            end else begin
                want = pending_delays.pop_front();
                if (got.delay != want.delay)
                    report_mismatch("retry wait", got.delay, want.delay);
                if (got.reach != want.reach)
                    report_mismatch("reachable", got.reach, want.reach);
                if (got.fails != want.fails)
                    report_mismatch("fail_count", got.fails, want.fails);
                if (want.fails == jbrt_pkg::FAIL_LIMIT_DEF)
                    at_fail_limit++;
                if (want.delay == jbrt_pkg::DELAY_MAX)
                    at_delay_ceiling++;
            end
        end
    end

    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int r;
        int mode;
        int blk;
        int count;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = jbrt_pkg::OP_START;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = jbrt_pkg::CFG_BASE_INTERVAL;
        cfg_data  = '0;
        cfg_base  = jbrt_pkg::BASE_RESET;
        cfg_cap   = jbrt_pkg::CAP_RESET;
        cfg_seed  = jbrt_pkg::SEED_RESET;
        gen_state = '0;
        fail_cnt  = '0;
        reach_flag = 1'b1;
        mismatches = 0;
        words_sent = 0;
        results_seen = 0;
        reg_writes = 0;
        at_fail_limit = 0;
        at_delay_ceiling = 0;
        sender_idle_pct = 17;
        recv_idle_pct = 87;

        // Outcomes before any start run the generator from zero
        stim_table.push_back(item_row(jbrt_pkg::OP_OUTCOME, ATTEMPT_FAIL));
        stim_table.push_back(item_row(jbrt_pkg::OP_OUTCOME, ATTEMPT_FAIL));
        stim_table.push_back(item_row(jbrt_pkg::OP_OUTCOME, ATTEMPT_OK));
        // Start ignores attempt_ok and reseeds each time
        stim_table.push_back(item_row(jbrt_pkg::OP_START, ATTEMPT_OK));
        stim_table.push_back(item_row(jbrt_pkg::OP_START, ATTEMPT_FAIL));
        // Zero base taken as 1 ms, cap below base, no jitter under 10 ms
        stim_table.push_back(cfg_row(jbrt_pkg::CFG_BASE_INTERVAL, 32'd0));
        stim_table.push_back(cfg_row(jbrt_pkg::CFG_BACKOFF_CAP, 32'd0));
        stim_table.push_back(typed_row(jbrt_pkg::OP_START, ATTEMPT_OK, 19'd1, 1'b1, 5'd0));
        stim_table.push_back(typed_row(jbrt_pkg::OP_OUTCOME, ATTEMPT_FAIL, 19'd1, 1'b0, 5'd1));
        stim_table.push_back(typed_row(jbrt_pkg::OP_OUTCOME, ATTEMPT_FAIL, 19'd1, 1'b0, 5'd2));
        stim_table.push_back(typed_row(jbrt_pkg::OP_OUTCOME, ATTEMPT_OK, 19'd1, 1'b1, 5'd0));
        // Small base grows past the no-jitter threshold
        stim_table.push_back(cfg_row(jbrt_pkg::CFG_BASE_INTERVAL, 32'd9));
        stim_table.push_back(cfg_row(jbrt_pkg::CFG_BACKOFF_CAP, 32'd1000));
        stim_table.push_back(cfg_row(jbrt_pkg::CFG_RNG_SEED, 32'd0));
        stim_table.push_back(typed_row(jbrt_pkg::OP_START, ATTEMPT_FAIL, 19'd9, 1'b1, 5'd0));
        for (r = 0; r < 3; r++)
            stim_table.push_back(item_row(jbrt_pkg::OP_OUTCOME, ATTEMPT_FAIL));
        // Widest cap: jittered delay may saturate at the ceiling
        stim_table.push_back(cfg_row(jbrt_pkg::CFG_BASE_INTERVAL, 32'h0000_FFFF));
        stim_table.push_back(cfg_row(jbrt_pkg::CFG_BACKOFF_CAP, 32'h0007_FFFF));
        stim_table.push_back(cfg_row(jbrt_pkg::CFG_RNG_SEED, 32'hFFFF_FFFF));
        stim_table.push_back(item_row(jbrt_pkg::OP_START, ATTEMPT_OK));
        for (r = 0; r < 5; r++)
            stim_table.push_back(item_row(jbrt_pkg::OP_OUTCOME, ATTEMPT_FAIL));
        // Cap below a large base
        stim_table.push_back(cfg_row(jbrt_pkg::CFG_BACKOFF_CAP, 32'd1000));
        stim_table.push_back(item_row(jbrt_pkg::OP_START, ATTEMPT_OK));
        stim_table.push_back(item_row(jbrt_pkg::OP_OUTCOME, ATTEMPT_FAIL));
        stim_table.push_back(item_row(jbrt_pkg::OP_OUTCOME, ATTEMPT_OK));
        // Write to an unused index changes nothing
        stim_table.push_back(cfg_row(CFG_UNUSED_IDX, 32'hA5A5_A5A5));
        stim_table.push_back(item_row(jbrt_pkg::OP_START, ATTEMPT_OK));

        // Hold reset, then release on a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Walk the directed table
        for (r = 0; r < stim_table.size(); r++) begin
            if (stim_table[r].is_cfg) begin
                quiesce();
                write_reg(stim_table[r].idx, stim_table[r].data);
            end else begin
                send_word(stim_table[r].op, stim_table[r].ok, stim_table[r].typed,
                          stim_table[r].res);
            end
        end

        // Random sessions under three idling patterns
        for (mode = 0; mode < 3; mode++) begin
            sender_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 87 : 0;
            recv_idle_pct   = (mode == 0) ? 87 : (mode == 1) ? 17 : 0;
            for (blk = mode * 3; blk < mode * 3 + 3; blk++) begin
                configure_block(blk);
                count = 0;
                while (count < WORDS_PER_BLK)
                    run_retry_burst(count);
            end
        end

        quiesce();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (pending_delays.size() != 0)
            report_mismatch("results never delivered", 0, pending_delays.size());

        $display("tb: %0d words sent, %0d results checked, %0d register writes",
                 words_sent, results_seen, reg_writes);
        $display("tb: %0d results at the failure limit, %0d at the delay ceiling",
                 at_fail_limit, at_delay_ceiling);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
